### src/park_miller_rng_hash_reseed_assert.svh
// Assertion macros for the minimal-standard generator block.
`ifndef PARK_MILLER_RNG_HASH_RESEED_ASSERT_SVH
`define PARK_MILLER_RNG_HASH_RESEED_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that an antecedent implies a consequent in the same cycle.
`define PMRH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmrh assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define PMRH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmrh assertion failed");

`else

`define PMRH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PMRH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/pmrh_pkg.sv
// Types, constants and microcode table of the minimal-standard generator.
package pmrh_pkg;

	localparam int unsigned STATE_W      = 31;
	localparam int unsigned MUL_W        = 15;
	localparam int unsigned PROD_W       = STATE_W + MUL_W;
	localparam int unsigned HASH_W       = 32;
	localparam int unsigned HASH_KEEP_W  = 27;
	localparam int unsigned HASH_BYTES   = 28;
	localparam int unsigned BYTE_CNT_W   = 5;
	localparam int unsigned WARMUP_STEPS = 5;
	localparam int unsigned REM_W        = 3;
	localparam int unsigned PAYLOAD_W    = 8 * HASH_BYTES;

	localparam logic [MUL_W-1:0]      MUL_A     = 15'd16807;
	localparam logic [STATE_W-1:0]    MOD_M     = 31'h7FFF_FFFF;
	localparam logic [BYTE_CNT_W-1:0] HASH_LAST = BYTE_CNT_W'(HASH_BYTES - 1);
	localparam logic [BYTE_CNT_W-1:0] HASH_END  = BYTE_CNT_W'(HASH_BYTES);
	localparam logic [REM_W-1:0]      WARM_REM  = REM_W'(WARMUP_STEPS - 1);

	typedef enum logic [1:0] {
		MODE_NEXT   = 2'd0,
		MODE_LOAD   = 2'd1,
		MODE_RESEED = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Datapath operation of one microcode step
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_HBYTE,
		OP_FIN1,
		OP_FIN2,
		OP_MUL,
		OP_FOLD,
		OP_EMIT
	} op_t;

	// How the step counter moves on
	typedef enum logic [2:0] {
		C_DISPATCH,
		C_NEXT,
		C_GOTO,
		C_LOOP_BYTE,
		C_LOOP_REM,
		C_WAIT_OUT
	} cond_t;

	typedef enum logic [2:0] {
		P_IDLE  = 3'd0,
		P_LOAD  = 3'd1,
		P_HBYTE = 3'd2,
		P_FIN1  = 3'd3,
		P_FIN2  = 3'd4,
		P_MUL   = 3'd5,
		P_FOLD  = 3'd6,
		P_EMIT  = 3'd7
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Read-only control store, one word per step
	function automatic ctrl_t ucode_rom(input step_t pc);
		ctrl_t w;
		case (pc)
			P_IDLE:  w = '{op: OP_NONE,  cond: C_DISPATCH,  target: P_IDLE};
			P_LOAD:  w = '{op: OP_LOAD,  cond: C_GOTO,      target: P_EMIT};
			P_HBYTE: w = '{op: OP_HBYTE, cond: C_LOOP_BYTE, target: P_HBYTE};
			P_FIN1:  w = '{op: OP_FIN1,  cond: C_NEXT,      target: P_IDLE};
			P_FIN2:  w = '{op: OP_FIN2,  cond: C_NEXT,      target: P_IDLE};
			P_MUL:   w = '{op: OP_MUL,   cond: C_NEXT,      target: P_IDLE};
			P_FOLD:  w = '{op: OP_FOLD,  cond: C_LOOP_REM,  target: P_MUL};
			P_EMIT:  w = '{op: OP_EMIT,  cond: C_WAIT_OUT,  target: P_IDLE};
			default: w = '{op: OP_NONE,  cond: C_GOTO,      target: P_IDLE};
		endcase
		return w;
	endfunction

endpackage

### src/park_miller_rng_hash_reseed.sv
// Top level: microcoded minimal-standard generator with hash reseed.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall   | mode, new_seed, hash_base, coord_x/y/z
//  out     | from block| out_valid / out_stall | random_value, seed_error
//
// Steps per request: mode 0 one multiply and one fold step of the shared modulo unit, then
// the result step; mode 1 the load and result steps; mode 3 only the result step; mode 2
// hashes 28 bytes, runs 2 finishing steps and 5 multiply/fold pairs, then the result step.
// Step counter: one control word per unstalled cycle; all arithmetic runs in one datapath.
// Reset sets the generator state to 1 and the sequencer to idle, with no request held.
// A stalled output holds the sequencer in its result step; input waits until it is idle.
`include "park_miller_rng_hash_reseed_assert.svh"

module park_miller_rng_hash_reseed
	import pmrh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic signed [31:0]  new_seed,
	input  logic signed [31:0]  hash_base,
	input  logic [63:0]         coord_x,
	input  logic [63:0]         coord_y,
	input  logic [63:0]         coord_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATE_W-1:0]  random_value,
	output logic                seed_error
);

	step_t                  pc_q;
	step_t                  pc_nxt;
	ctrl_t                  ctrl;
	logic [STATE_W-1:0]     state_q;
	logic [BYTE_CNT_W-1:0]  byte_q;
	logic [REM_W-1:0]       rem_q;
	logic                   out_valid_q;
	logic [STATE_W-1:0]     random_value_q;
	logic                   seed_error_q;
	logic [31:0]            seed_q;
	logic [PAYLOAD_W-1:0]   bytes_q;
	logic [HASH_W-1:0]      hash_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   err_q;

	logic                   in_accept;
	logic                   out_free;
	logic                   seed_bad;
	logic [7:0]             hbyte;
	logic [HASH_W-1:0]      hext;
	logic [HASH_W-1:0]      mix_a;
	logic [HASH_W-1:0]      mix_b;
	logic [HASH_W-1:0]      mix_h;
	logic [HASH_W-1:0]      fin1_a;
	logic [HASH_W-1:0]      fin1_h;
	logic [HASH_W-1:0]      fin2_a;
	logic [HASH_KEEP_W-1:0] fin2_keep;
	logic [STATE_W-1:0]     fin2_seed;
	logic [STATE_W:0]       fold_sum;
	logic [STATE_W:0]       fold_mod;
	logic [STATE_W-1:0]     folded;

	// Handshake
	assign in_accept = in_valid && (pc_q == P_IDLE);
	assign in_stall  = (pc_q != P_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Fetch the control word of the current step
	always_comb begin
		ctrl = ucode_rom(pc_q);
	end

	// Next step
	always_comb begin
		pc_nxt = pc_q;
		case (ctrl.cond)
			C_DISPATCH: begin
				if (in_accept) begin
					case (mode_t'(mode))
						MODE_NEXT:   pc_nxt = P_MUL;
						MODE_LOAD:   pc_nxt = P_LOAD;
						MODE_RESEED: pc_nxt = P_HBYTE;
						default:     pc_nxt = P_EMIT;
					endcase
				end else begin
					pc_nxt = P_IDLE;
				end
			end
			C_NEXT:      pc_nxt = step_t'(pc_q + 3'd1);
			C_GOTO:      pc_nxt = ctrl.target;
			C_LOOP_BYTE: pc_nxt = (byte_q != HASH_LAST) ? ctrl.target : step_t'(pc_q + 3'd1);
			C_LOOP_REM:  pc_nxt = (rem_q != '0) ? ctrl.target : step_t'(pc_q + 3'd1);
			C_WAIT_OUT:  pc_nxt = out_free ? ctrl.target : pc_q;
			default:     pc_nxt = P_IDLE;
		endcase
	end

	// Seed check for a direct load
	assign seed_bad = (seed_q == 32'd0) || seed_q[31];

	// One-at-a-time mix of the lowest queued byte, sign-extended
	assign hbyte = bytes_q[7:0];
	assign hext  = {{24{hbyte[7]}}, hbyte};
	assign mix_a = hash_q + hext;
	assign mix_b = mix_a + {mix_a[HASH_W-11:0], 10'b0};
	assign mix_h = mix_b ^ {6'b0, mix_b[HASH_W-1:6]};

	// Hash finish, first half
	assign fin1_a = hash_q + {hash_q[HASH_W-4:0], 3'b0};
	assign fin1_h = fin1_a ^ {11'b0, fin1_a[HASH_W-1:11]};

	// Hash finish, second half: keep 27 bits, zero becomes one
	assign fin2_a    = hash_q + {hash_q[HASH_W-16:0], 15'b0};
	assign fin2_keep = fin2_a[HASH_KEEP_W-1:0];
	assign fin2_seed = (fin2_keep == '0) ? STATE_W'(1)
		: {{(STATE_W-HASH_KEEP_W){1'b0}}, fin2_keep};

	// Fold the product modulo 2^31-1: high part plus low part, one subtract
	assign fold_sum = {1'b0, prod_q[STATE_W-1:0]}
		+ {{(STATE_W+1-MUL_W){1'b0}}, prod_q[PROD_W-1:STATE_W]};
	assign fold_mod = (fold_sum >= {1'b0, MOD_M}) ? (fold_sum - {1'b0, MOD_M}) : fold_sum;
	assign folded   = fold_mod[STATE_W-1:0];

	// Control state, generator state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_IDLE;
			state_q     <= STATE_W'(1);
			byte_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_nxt;
			case (ctrl.op)
				OP_NONE: begin
					if (in_accept) begin
						byte_q <= '0;
						rem_q  <= '0;
					end
				end
				OP_LOAD: begin
					if (!seed_bad) begin
						state_q <= seed_q[STATE_W-1:0];
					end
				end
				OP_HBYTE: byte_q <= byte_q + 1'b1;
				OP_FIN2: begin
					state_q <= fin2_seed;
					rem_q   <= WARM_REM;
				end
				OP_FOLD: begin
					state_q <= folded;
					if (rem_q != '0) begin
						rem_q <= rem_q - 1'b1;
					end
				end
				default: ;
			endcase
			// Drop the result once taken, raise it from the result step
			if ((ctrl.op == OP_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_NONE: begin
				if (in_accept) begin
					seed_q  <= new_seed;
					bytes_q <= {coord_z, coord_y, coord_x, hash_base};
					hash_q  <= '0;
					err_q   <= 1'b0;
				end
			end
			OP_LOAD:  err_q <= seed_bad;
			OP_HBYTE: begin
				hash_q  <= mix_h;
				bytes_q <= {8'b0, bytes_q[PAYLOAD_W-1:8]};
			end
			OP_FIN1:  hash_q <= fin1_h;
			OP_MUL:   prod_q <= {{MUL_W{1'b0}}, state_q} * {{STATE_W{1'b0}}, MUL_A};
			OP_EMIT: begin
				if (out_free) begin
					random_value_q <= state_q;
					seed_error_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;
	assign seed_error   = seed_error_q;

	// A fold never leaves the modulus itself in the state
	`PMRH_ASSERT_NXT(a_fold_reduced, clk, arst_n, pc_q == P_FOLD, state_q != MOD_M)
	// The hash loop leaves only after every byte has been mixed
	`PMRH_ASSERT_IMP(a_hash_count, clk, arst_n, pc_q == P_FIN1, byte_q == HASH_END)
	// A new result appears only out of the result step
	`PMRH_ASSERT_IMP(a_emit_source, clk, arst_n, $rose(out_valid_q), $past(pc_q) == P_EMIT)
	// The result step does not linger while the output register is empty
	`PMRH_ASSERT_NXT(a_emit_drains, clk, arst_n, (pc_q == P_EMIT) && !out_valid_q,
		pc_q == P_IDLE)

endmodule

### bench/tb.sv
// Testbench for the minimal-standard generator with hash reseed: directed and random requests.
`timescale 1ns / 1ps

module tb;
	import pmrh_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 64;
	localparam int IDLE_PCT    = 29;

	typedef struct packed {
		logic [STATE_W-1:0] value;
		logic               err;
	} draw_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = MODE_NEXT;
	logic signed [31:0] new_seed = '0;
	logic signed [31:0] hash_base = '0;
	logic [63:0]        coord_x = '0;
	logic [63:0]        coord_y = '0;
	logic [63:0]        coord_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [STATE_W-1:0] random_value;
	logic               seed_error;

	logic [STATE_W-1:0] gen_state;
	draw_t              pending_draws[$];
	int                 mismatches = 0;
	int                 quiet_cycles = 0;
	bit                 in_idle_en = 1'b1;
	bit                 out_idle_en = 1'b1;

	park_miller_rng_hash_reseed DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.new_seed(new_seed),
		.hash_base(hash_base),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.random_value(random_value),
		.seed_error(seed_error)
	);

	always #2 clk = ~clk;

	// One step of the congruential recurrence
	function automatic logic [STATE_W-1:0] pm_advance(input logic [STATE_W-1:0] s);
		logic [63:0] prod;
		prod = 64'(s) * 64'(MUL_A);
		return STATE_W'(prod % 64'(MOD_M));
	endfunction

	// Fold one sign-extended byte into the one-at-a-time hash
	function automatic logic [31:0] hash_mix(input logic [31:0] h, input logic [7:0] b);
		h = h + {{24{b[7]}}, b};
		h = h + (h << 10);
		h = h ^ (h >> 6);
		return h;
	endfunction

	// Hash base and coordinates, keep 27 bits, then warm up
	function automatic logic [STATE_W-1:0] reseed_value(input logic [31:0] base,
			input logic [63:0] x, input logic [63:0] y, input logic [63:0] z);
		logic [8*HASH_BYTES-1:0] bytes_le;
		logic [31:0]             h;
		logic [STATE_W-1:0]      s;
		bytes_le = {z, y, x, base};
		h = '0;
		for (int i = 0; i < HASH_BYTES; i++)
			h = hash_mix(h, bytes_le[8*i +: 8]);
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		s = STATE_W'(h[HASH_KEEP_W-1:0]);
		if (s == '0)
			s = STATE_W'(1);
		repeat (WARMUP_STEPS) s = pm_advance(s);
		return s;
	endfunction

	// Update the predicted state for one request and return the draw it yields
	function automatic draw_t next_draw(input mode_t m, input logic signed [31:0] seed,
			input logic [31:0] base, input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] z);
		draw_t d;
		d.err = 1'b0;
		case (m)
			MODE_NEXT: gen_state = pm_advance(gen_state);
			MODE_LOAD: begin
				if (seed > 0)
					gen_state = seed[STATE_W-1:0];
				else
					d.err = 1'b1;
			end
			MODE_RESEED: gen_state = reseed_value(base, x, y, z);
			default: ;
		endcase
		d.value = gen_state;
		return d;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Present one request, hold it until taken, then record its draw
	task automatic send_request(input mode_t m, input logic signed [31:0] seed,
			input logic [31:0] base, input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] z);
		while (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		new_seed  <= seed;
		hash_base <= base;
		coord_x   <= x;
		coord_y   <= y;
		coord_z   <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_draws.push_back(next_draw(m, seed, base, x, y, z));
	endtask

	// Drop valid and hold until every draw has come back
	task automatic wait_for_draws();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_draws.size() != 0) @(posedge clk);
	endtask

	// One request of random mode and content
	task automatic send_random_request();
		int unsigned        pick;
		logic signed [31:0] seed;
		logic [63:0]        x;
		pick = $urandom_range(99);
		if (pick < 60) begin
			send_request(MODE_NEXT, $urandom, $urandom, rand_word(), rand_word(), rand_word());
		end else if (pick < 76) begin
			case ($urandom_range(9))
				0: seed = 0;
				1: seed = 32'h8000_0000 | $urandom;
				2: seed = $urandom_range(1, 1000);
				3: seed = ($urandom_range(19) == 0) ? 32'h7FFF_FFFF : 32'h7FFF_FFFE;
				default: seed = $urandom & 32'h7FFF_FFFF;
			endcase
			send_request(MODE_LOAD, seed, $urandom, rand_word(), rand_word(), rand_word());
		end else if (pick < 90) begin
			if ($urandom_range(1))
				x = $realtobits($urandom_range(0, 20000) / 10.0 - 1000.0);
			else
				x = rand_word();
			send_request(MODE_RESEED, $urandom, $urandom, x, rand_word(),
				$realtobits($urandom_range(0, 5000) / 7.0));
		end else begin
			send_request(MODE_NONE, $urandom, $urandom, rand_word(), rand_word(), rand_word());
		end
	endtask

	// Field extremes, every mode and the corner cases of seeding
	task automatic test_directed();
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		send_request(MODE_NEXT, -1, -1, '1, '1, '1);
		// bad seeds: zero, minus one, most negative
		send_request(MODE_LOAD, 0, 0, '0, '0, '0);
		send_request(MODE_LOAD, -1, 0, '0, '0, '0);
		send_request(MODE_LOAD, 32'sh8000_0000, 0, '0, '0, '0);
		// seed equal to the modulus is taken, and the next step collapses the state to zero
		send_request(MODE_LOAD, 32'sh7FFF_FFFF, 0, '0, '0, '0);
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		send_request(MODE_NONE, -1, -1, '1, '1, '1);
		send_request(MODE_LOAD, 1, 0, '0, '0, '0);
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		send_request(MODE_LOAD, 32'sh7FFF_FFFE, 0, '0, '0, '0);
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		// reseed with extreme bases and coordinates
		send_request(MODE_RESEED, 0, 0, '0, '0, '0);
		send_request(MODE_RESEED, -1, -1, '1, '1, '1);
		send_request(MODE_RESEED, 0, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		send_request(MODE_RESEED, 0, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(MODE_RESEED, 0, 12345, $realtobits(1.5), $realtobits(-2.25),
			$realtobits(100.0));
		// error flag stays low outside the load mode
		send_request(MODE_NONE, 0, 0, '0, '0, '0);
		send_request(MODE_NEXT, -1, 0, '0, '0, '0);
		send_request(MODE_LOAD, 12345, 0, '0, '0, '0);
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		send_request(MODE_NEXT, 0, 0, '0, '0, '0);
		wait_for_draws();
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_random_request();
		wait_for_draws();
	endtask

	// Back-to-back stream with no idling on either side
	task automatic test_burst(input int count);
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		repeat (count) begin
			if ($urandom_range(19) == 0)
				send_request(MODE_LOAD, $urandom_range(1, 32'h7FFF_FFFE), $urandom,
					rand_word(), rand_word(), rand_word());
			else
				send_request(MODE_NEXT, $urandom, $urandom, rand_word(), rand_word(),
					rand_word());
		end
		wait_for_draws();
		in_idle_en  = 1'b1;
		out_idle_en = 1'b1;
	endtask

	// Short rounds, each ending with the sender held until all draws are back
	task automatic test_pause_rounds(input int rounds, input int per_round);
		repeat (rounds) begin
			repeat (per_round) send_random_request();
			wait_for_draws();
		end
	endtask

	// Stall the result side at random
	always @(posedge clk)
		out_stall <= out_idle_en && ($urandom_range(99) < IDLE_PCT);

	// Compare each taken draw with the oldest prediction
	always @(posedge clk) begin : check_draw
		draw_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("draw with nothing pending", 64'(random_value), 64'd0);
			end else begin
				want = pending_draws.pop_front();
				if (random_value !== want.value)
					report_mismatch("random_value", 64'(random_value), 64'(want.value));
				if (seed_error !== want.err)
					report_mismatch("seed_error", 64'(seed_error), 64'(want.err));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		gen_state = STATE_W'(1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(1150);
		test_burst(350);
		test_pause_rounds(4, 60);
		wait_for_draws();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
